// File: design/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and codes of the linear probe hash table
// Operation, status and slot state codes, the used-count ceiling and the
// state type of the back end.
// ----------------------------------------------------------------------------
package lpht_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_PURGE  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] SL_FREE    = 2'd0;
    localparam logic [1:0] SL_USED    = 2'd1;
    localparam logic [1:0] SL_DELETED = 2'd2;

    localparam logic [4:0] USED_MAX = 5'd31;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MOD,
        BE_PROBE,
        BE_COMMIT,
        BE_OUT
    } be_state_t;

endpackage

// File: design/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open-addressing hash table, linear probing
// Insert, remove, lookup and purge on a table of up to SLOTS slots with
// deleted-slot markers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                                      Handshake
//  request   in         s_op, s_key, s_value                       s_valid/s_ready
//  result    out        m_status, m_found, m_slot, m_used_out      m_valid/m_ready
//  config    in         cfg_wdata                                  cfg_we
//
// An operation reduces the byte sum by repeated subtraction of n, where n is
// the size in use, then walks the slots, one slot per cycle.
// Reset is synchronous on aresetn low; every slot becomes free and the size
// returns to ten. A two-entry queue keeps requests flowing while the engine
// works or while a result waits for m_ready.
module linear_probe_hash_table_core import lpht_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int KEY_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [3:0]  m_slot,
    output logic [4:0]  m_used_out
);
    // Queue between intake and the table engine.
    logic        q_valid, q_pop;
    op_t         q_op;
    logic [63:0] q_key;
    logic [31:0] q_value;
    logic [10:0] q_sum;

    lpht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_key, .s_value,
        .q_valid, .q_pop, .q_op, .q_key, .q_value, .q_sum
    );

    lpht_back #(.SLOTS(SLOTS)) u_back (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .q_valid, .q_pop, .q_op, .q_key, .q_value, .q_sum,
        .m_valid, .m_ready, .m_status, .m_found, .m_slot, .m_used_out
    );
endmodule

// File: design/lpht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_front: request intake
// Accepts a request, cuts the key at its first zero byte, forms the byte
// sum, and pushes the classified request into a two-entry queue.
// ----------------------------------------------------------------------------
module lpht_front import lpht_pkg::*; #(
    parameter int KEY_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [31:0] s_value,
    output logic        q_valid,
    input  logic        q_pop,
    output op_t         q_op,
    output logic [63:0] q_key,
    output logic [31:0] q_value,
    output logic [10:0] q_sum
);
    logic [63:0] canon;
    logic [10:0] sum;
    logic        live;

    always_comb begin
        canon = '0;
        sum   = '0;
        live  = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= KEY_BYTES || s_key[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                canon[8*b +: 8] = s_key[8*b +: 8];
                sum = sum + {3'd0, s_key[8*b +: 8]};
            end
        end
    end

    op_t         op_reg [2];
    logic [63:0] key_reg [2];
    logic [31:0] val_reg [2];
    logic [10:0] sum_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = op_reg[rp_reg];
    assign q_key   = key_reg[rp_reg];
    assign q_value = val_reg[rp_reg];
    assign q_sum   = sum_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            op_reg[wp_reg]  <= op_t'(s_op);
            key_reg[wp_reg] <= canon;
            val_reg[wp_reg] <= s_value;
            sum_reg[wp_reg] <= sum;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// File: design/lpht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_back: table engine
// Reduces the byte sum modulo the size in use, walks the slots one per
// cycle, applies the operation and holds the result for the output side.
// ----------------------------------------------------------------------------
module lpht_back import lpht_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        q_valid,
    output logic        q_pop,
    input  op_t         q_op,
    input  logic [63:0] q_key,
    input  logic [31:0] q_value,
    input  logic [10:0] q_sum,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [3:0]  m_slot,
    output logic [4:0]  m_used_out
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int CW = (NW > 11) ? NW : 11;

    logic [4:0]    size_reg;
    logic [NW-1:0] n_eff;
    always_comb begin
        if (size_reg == 5'd0) n_eff = NW'(1);
        else if (32'(size_reg) > SLOTS) n_eff = NW'(SLOTS);
        else n_eff = NW'(size_reg);
    end

    logic [1:0]  stat_reg [SLOTS];
    logic [63:0] key_mem [SLOTS];
    logic [31:0] val_mem [SLOTS];

    be_state_t     state_reg, state_next;
    op_t           op_reg;
    logic [63:0]   key_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] rem_reg;
    logic [AW-1:0] idx_reg;
    logic [NW-1:0] cnt_reg;
    logic          hole_reg, match_reg;
    logic [AW-1:0] hole_idx_reg, match_idx_reg;
    logic [4:0]    used_reg;
    logic [4:0]    freed_reg;
    logic [1:0]    status_reg;
    logic          found_reg;
    logic [3:0]    slot_reg;

    logic [1:0]  cur_st;
    logic [63:0] cur_key;
    logic        probe_done;
    assign cur_st  = stat_reg[idx_reg];
    assign cur_key = key_mem[idx_reg];
    assign probe_done = (cnt_reg == n_eff) || match_reg;

    always_comb begin
        state_next = state_reg;
        q_pop = 1'b0;
        case (state_reg)
            BE_IDLE: if (q_valid) begin
                q_pop = 1'b1;
                state_next = BE_MOD;
            end
            BE_MOD: if (rem_reg < CW'(n_eff)) state_next = BE_PROBE;
            BE_PROBE: if (probe_done) state_next = BE_COMMIT;
            BE_COMMIT: state_next = BE_OUT;
            BE_OUT: if (m_ready) state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    assign m_valid    = (state_reg == BE_OUT);
    assign m_status   = status_reg;
    assign m_found    = found_reg;
    assign m_slot     = slot_reg;
    assign m_used_out = used_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            BE_IDLE: begin
                op_reg    <= q_op;
                key_reg   <= q_key;
                val_reg   <= q_value;
                rem_reg   <= CW'(q_sum);
                cnt_reg   <= '0;
                hole_reg  <= 1'b0;
                match_reg <= 1'b0;
                freed_reg <= '0;
            end
            BE_MOD: begin
                // Repeated subtraction of the size in use; the sum stays
                // below 2041.
                if (rem_reg >= CW'(n_eff)) rem_reg <= rem_reg - CW'(n_eff);
                else if (op_reg == OP_INSERT || op_reg == OP_REMOVE)
                    idx_reg <= AW'(rem_reg);
                else idx_reg <= '0;
            end
            BE_PROBE: if (!probe_done) begin
                cnt_reg <= cnt_reg + NW'(1);
                if (32'(idx_reg) + 1 >= 32'(n_eff)) idx_reg <= '0;
                else idx_reg <= idx_reg + AW'(1);
                case (op_reg)
                    OP_PURGE: if (cur_st == SL_DELETED) begin
                        stat_reg[idx_reg] <= SL_FREE;
                        freed_reg <= freed_reg + 5'd1;
                    end
                    default: begin
                        if (cur_st == SL_USED) begin
                            if (cur_key == key_reg) begin
                                match_reg <= 1'b1;
                                match_idx_reg <= idx_reg;
                            end
                        end else if (!hole_reg && op_reg != OP_LOOKUP) begin
                            hole_reg <= 1'b1;
                            hole_idx_reg <= idx_reg;
                        end
                    end
                endcase
            end
            BE_COMMIT: begin
                status_reg <= ST_OK;
                found_reg  <= 1'b0;
                slot_reg   <= 4'd0;
                case (op_reg)
                    OP_INSERT: begin
                        if (match_reg) begin
                            val_mem[match_idx_reg] <= val_reg;
                            found_reg <= 1'b1;
                            slot_reg  <= 4'(match_idx_reg);
                        end else if (hole_reg) begin
                            if (stat_reg[hole_idx_reg] == SL_FREE && used_reg < USED_MAX)
                                used_reg <= used_reg + 5'd1;
                            stat_reg[hole_idx_reg] <= SL_USED;
                            key_mem[hole_idx_reg]  <= key_reg;
                            val_mem[hole_idx_reg]  <= val_reg;
                            slot_reg <= 4'(hole_idx_reg);
                        end else status_reg <= ST_FULL;
                    end
                    OP_REMOVE, OP_LOOKUP: begin
                        if (match_reg) begin
                            if (op_reg == OP_REMOVE)
                                stat_reg[match_idx_reg] <= SL_DELETED;
                            found_reg <= 1'b1;
                            slot_reg  <= 4'(match_idx_reg);
                        end else status_reg <= ST_NOT_FOUND;
                    end
                    default: used_reg <= (used_reg > freed_reg) ? used_reg - freed_reg : 5'd0;
                endcase
            end
            default: ;
        endcase
        if (cfg_we) size_reg <= cfg_wdata;
        if (!aresetn) begin
            state_reg <= BE_IDLE;
            size_reg  <= 5'd10;
            used_reg  <= 5'd0;
            for (int i = 0; i < SLOTS; i++) stat_reg[i] <= SL_FREE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
